// ----- sv/tss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the task slot scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

  // Table geometry
  localparam int unsigned SLOTS = 64;
  localparam int unsigned IDX_W = 6;
  localparam logic [6:0]  NO_SLOT = 7'(SLOTS);

  // Operation codes
  localparam logic [2:0] OP_CREATE       = 3'd0;
  localparam logic [2:0] OP_SCHEDULE     = 3'd1;
  localparam logic [2:0] OP_BLOCK        = 3'd2;
  localparam logic [2:0] OP_UNBLOCK      = 3'd3;
  localparam logic [2:0] OP_SLEEP        = 3'd4;
  localparam logic [2:0] OP_WAKEUP       = 3'd5;
  localparam logic [2:0] OP_SET_COUNTERS = 3'd6;

  // Task states
  localparam logic [2:0] TS_READY    = 3'd0;
  localparam logic [2:0] TS_RUNNING  = 3'd1;
  localparam logic [2:0] TS_BLOCKED  = 3'd2;
  localparam logic [2:0] TS_SLEEPING = 3'd3;
  localparam logic [2:0] TS_WAITING  = 3'd4;

  // Result status codes
  localparam logic [1:0] RS_OK      = 2'd0;
  localparam logic [1:0] RS_FULL    = 2'd1;
  localparam logic [1:0] RS_INVALID = 2'd2;

  // Configuration register index
  localparam logic REG_MS_PER_TICK = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_SCAN,
    S_RUNRD,
    S_RELEASE,
    S_CLAIM,
    S_DONE
  } seq_state_t;

  // What a table scan is doing
  typedef enum logic [1:0] {
    SCAN_CREATE,
    SCAN_SCHED,
    SCAN_WAKE
  } scan_mode_t;

endpackage

// ----- sv/tss_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_req_if / tss_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface tss_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [5:0]  slot;
  logic [7:0]  priority_req;
  logic [2:0]  block_state;
  logic [19:0] wait_ms;
  logic [31:0] now;
  logic [31:0] slice_ticks;
  logic [31:0] last_run;

  modport source (output valid, operation, slot, priority_req, block_state, wait_ms,
                  now, slice_ticks, last_run, input ready);
  modport sink (input valid, operation, slot, priority_req, block_state, wait_ms,
                now, slice_ticks, last_run, output ready);
endinterface

interface tss_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] chosen_slot;
  logic       switched;
  logic [6:0] woken_count;
  logic [1:0] status;

  modport source (output valid, chosen_slot, switched, woken_count, status, input ready);
  modport sink (input valid, chosen_slot, switched, woken_count, status, output ready);
endinterface

// ----- sv/task_slot_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_slot_scheduler
// Task table of 64 slots with create, schedule, block, unblock, sleep,
// wakeup and counter-load operations, run by a small sequencer.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. Block (not running), unblock, set
// counters and bad requests finish without a scan. Create walks the slot-used
// bits until it finds a free one. Schedule and wakeup walk every slot through
// one registered read port of the task memories. Sleep first runs a bit-serial
// divider, then its schedule. The result beat sits in an output register, so
// the next request is taken while it waits.
module task_slot_scheduler (
  input  logic        clk,
  input  logic        rst,
  tss_req_if.sink     req,
  tss_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tss_pkg::*;

  localparam logic [6:0] SLOT_END = 7'(SLOTS);

  // Configuration
  logic [9:0] ms_per_tick;

  // Latched request
  logic [2:0]  op_r;
  logic [5:0]  slot_r;
  logic [7:0]  prio_r;
  logic [2:0]  bstate_r;
  logic [19:0] wms_r;
  logic [31:0] now_r;
  logic [31:0] sticks_r;
  logic [31:0] lrun_r;

  // Table state
  logic [SLOTS-1:0] used;
  logic [6:0]       running;
  logic [6:0]       idle;
  logic [2:0]       status_mem [SLOTS];
  logic [31:0]      ticks_mem  [SLOTS];
  logic [31:0]      lr_mem     [SLOTS];
  logic [2:0]       rd_status;
  logic [31:0]      rd_ticks;
  logic [31:0]      rd_lr;
  logic [IDX_W-1:0] rd_addr;

  // Sequencer
  seq_state_t state, state_next;
  scan_mode_t mode;
  logic [6:0]       cnt;
  logic             eval_vld;
  logic [IDX_W-1:0] eval_idx;
  logic [6:0]       pick;
  logic [31:0]      pick_ticks;
  logic [31:0]      pick_lr;
  logic [6:0]       final_pick;

  // Result
  logic [6:0] res_chosen;
  logic       res_switched;
  logic [6:0] res_woken;
  logic [1:0] res_status;
  logic       out_valid;
  logic [6:0] out_chosen;
  logic       out_switched;
  logic [6:0] out_woken;
  logic [1:0] out_status;

  // Memory write ports
  logic             st_we, tk_we, lr_we;
  logic [IDX_W-1:0] st_wa, tk_wa, lr_wa;
  logic [2:0]       st_wd;
  logic [31:0]      tk_wd, lr_wd;

  // Divider
  logic        div_start;
  logic        div_done;
  logic [19:0] div_q;
  logic [19:0] wake_delta;

  // Decode helpers
  logic bstate_ok;
  logic slot_in_use;
  logic slot_is_running;
  logic scan_end;
  logic create_hit;
  logic sched_take;
  logic wake_hit;
  logic out_free;

  assign bstate_ok       = (bstate_r >= TS_BLOCKED) && (bstate_r <= TS_WAITING);
  assign slot_in_use     = used[slot_r];
  assign slot_is_running = ({1'b0, slot_r} == running);
  assign scan_end        = (cnt == SLOT_END) && !eval_vld;
  assign create_hit      = !used[cnt[IDX_W-1:0]];
  assign final_pick      = (pick == NO_SLOT) ? idle : pick;
  assign sched_take      = eval_vld && used[eval_idx] && (rd_status == TS_READY) &&
                           ({1'b0, eval_idx} != running) &&
                           ((pick == NO_SLOT) || (pick_ticks < rd_ticks) ||
                            (rd_lr < pick_lr));
  assign wake_hit        = eval_vld && used[eval_idx] && (rd_status == TS_SLEEPING) &&
                           (rd_ticks <= now_r);
  assign out_free        = !out_valid || rsp.ready;
  assign wake_delta      = (div_q == '0) ? 20'd1 : div_q;

  // ---------------- APB configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MS_PER_TICK) ? {22'd0, ms_per_tick} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_per_tick <= 10'd10;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MS_PER_TICK)) begin
      ms_per_tick <= pwdata[9:0];
    end
  end

  // ---------------- Divider ----------------
  assign div_start = (state == S_EXEC) && (op_r == OP_SLEEP) && (running != NO_SLOT);

  tss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (wms_r),
    .divisor  (ms_per_tick),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------- Next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (op_r) inside
          OP_CREATE, OP_SCHEDULE, OP_WAKEUP: state_next = S_SCAN;
          OP_BLOCK: begin
            if (slot_in_use && bstate_ok && slot_is_running) state_next = S_SCAN;
            else state_next = S_DONE;
          end
          OP_SLEEP: begin
            state_next = (running == NO_SLOT) ? S_DONE : S_DIV;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DIV: begin
        if (div_done) state_next = S_SCAN;
      end
      S_SCAN: begin
        unique case (mode)
          SCAN_CREATE: begin
            if (create_hit || (cnt == SLOT_END - 7'd1)) state_next = S_DONE;
          end
          SCAN_WAKE: begin
            if (scan_end) state_next = S_DONE;
          end
          default: begin
            if (scan_end) state_next = (final_pick == NO_SLOT) ? S_DONE : S_RUNRD;
          end
        endcase
      end
      S_RUNRD:   state_next = S_RELEASE;
      S_RELEASE: state_next = S_CLAIM;
      S_CLAIM:   state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // ---------------- Sequencer outputs: memory ports ----------------
  always_comb begin
    st_we = 1'b0; st_wa = slot_r; st_wd = TS_READY;
    tk_we = 1'b0; tk_wa = slot_r; tk_wd = sticks_r;
    lr_we = 1'b0; lr_wa = slot_r; lr_wd = lrun_r;
    rd_addr = cnt[IDX_W-1:0];
    unique case (state)
      S_EXEC: begin
        if (op_r == OP_BLOCK && slot_in_use && bstate_ok) begin
          st_we = 1'b1;
          st_wd = bstate_r;
        end else if (op_r == OP_UNBLOCK && slot_in_use) begin
          st_we = 1'b1;
          st_wd = TS_READY;
        end else if (op_r == OP_SET_COUNTERS) begin
          tk_we = 1'b1;
          lr_we = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          st_we = 1'b1;
          st_wa = running[IDX_W-1:0];
          st_wd = TS_SLEEPING;
          tk_we = 1'b1;
          tk_wa = running[IDX_W-1:0];
          tk_wd = now_r + {12'd0, wake_delta};
        end
      end
      S_SCAN: begin
        if (mode == SCAN_CREATE && create_hit) begin
          st_we = 1'b1; st_wa = cnt[IDX_W-1:0]; st_wd = TS_READY;
          tk_we = 1'b1; tk_wa = cnt[IDX_W-1:0]; tk_wd = {24'd0, prio_r};
          lr_we = 1'b1; lr_wa = cnt[IDX_W-1:0]; lr_wd = '0;
        end else if (mode == SCAN_WAKE && wake_hit) begin
          st_we = 1'b1; st_wa = eval_idx; st_wd = TS_READY;
          tk_we = 1'b1; tk_wa = eval_idx; tk_wd = '0;
        end
      end
      S_RUNRD: begin
        rd_addr = running[IDX_W-1:0];
      end
      S_RELEASE: begin
        if (running != NO_SLOT && rd_status == TS_RUNNING) begin
          st_we = 1'b1;
          st_wa = running[IDX_W-1:0];
          st_wd = TS_READY;
        end
      end
      S_CLAIM: begin
        st_we = 1'b1;
        st_wa = pick[IDX_W-1:0];
        st_wd = TS_RUNNING;
      end
      default: ;
    endcase
  end

  // ---------------- Task memories ----------------
  always_ff @(posedge clk) begin
    if (st_we) status_mem[st_wa] <= st_wd;
    if (tk_we) ticks_mem[tk_wa] <= tk_wd;
    if (lr_we) lr_mem[lr_wa] <= lr_wd;
    rd_status <= status_mem[rd_addr];
    rd_ticks  <= ticks_mem[rd_addr];
    rd_lr     <= lr_mem[rd_addr];
  end

  // ---------------- Control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      running  <= NO_SLOT;
      idle     <= NO_SLOT;
      eval_vld <= 1'b0;
    end else begin
      eval_vld <= (state == S_SCAN) && (mode != SCAN_CREATE) && (cnt < SLOT_END);
      if (state == S_SCAN && mode == SCAN_CREATE && create_hit) begin
        used[cnt[IDX_W-1:0]] <= 1'b1;
        if (idle == NO_SLOT) idle <= cnt;
      end
      if (state == S_CLAIM) running <= pick;
    end
  end

  // ---------------- Working registers ----------------
  always_ff @(posedge clk) begin
    eval_idx <= cnt[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_r     <= req.operation;
          slot_r   <= req.slot;
          prio_r   <= req.priority_req;
          bstate_r <= req.block_state;
          wms_r    <= req.wait_ms;
          now_r    <= req.now;
          sticks_r <= req.slice_ticks;
          lrun_r   <= req.last_run;
        end
      end
      S_EXEC: begin
        cnt          <= '0;
        pick         <= NO_SLOT;
        res_chosen   <= NO_SLOT;
        res_switched <= 1'b0;
        res_woken    <= '0;
        res_status   <= RS_OK;
        case (op_r)
          OP_CREATE: mode <= SCAN_CREATE;
          OP_WAKEUP: mode <= SCAN_WAKE;
          default:   mode <= SCAN_SCHED;
        endcase
        case (op_r) inside
          OP_CREATE, OP_SCHEDULE, OP_WAKEUP, OP_SET_COUNTERS: ;
          OP_BLOCK: begin
            if (!slot_in_use || !bstate_ok) res_status <= RS_INVALID;
          end
          OP_UNBLOCK: begin
            if (!slot_in_use) res_status <= RS_INVALID;
          end
          OP_SLEEP: begin
            if (running == NO_SLOT) res_status <= RS_INVALID;
          end
          default: res_status <= RS_INVALID;
        endcase
      end
      S_SCAN: begin
        if (cnt < SLOT_END) cnt <= cnt + 7'd1;
        case (mode)
          SCAN_CREATE: begin
            if (create_hit) begin
              res_chosen <= cnt;
            end else if (cnt == SLOT_END - 7'd1) begin
              res_status <= RS_FULL;
            end
          end
          SCAN_WAKE: begin
            if (wake_hit) res_woken <= res_woken + 7'd1;
          end
          default: begin
            if (sched_take) begin
              pick       <= {1'b0, eval_idx};
              pick_ticks <= rd_ticks;
              pick_lr    <= rd_lr;
            end
            if (scan_end) begin
              pick <= final_pick;
              if (final_pick == NO_SLOT) res_status <= RS_INVALID;
            end
          end
        endcase
      end
      S_CLAIM: begin
        res_chosen   <= pick;
        res_switched <= (pick != running);
      end
      default: ;
    endcase
  end

  // ---------------- Output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_chosen   <= res_chosen;
      out_switched <= res_switched;
      out_woken    <= res_woken;
      out_status   <= res_status;
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.chosen_slot = out_chosen;
  assign rsp.switched    = out_switched;
  assign rsp.woken_count = out_woken;
  assign rsp.status      = out_status;

endmodule

// ----- sv/tss_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_div
// Restoring divider, one quotient bit per cycle, for sleep durations.
// ----------------------------------------------------------------------------
module tss_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [19:0] dividend,
  input  logic [9:0]  divisor,
  output logic        done,
  output logic [19:0] quotient
);

  logic        busy;
  logic [4:0]  step;
  logic [9:0]  rem;
  logic [19:0] quo;
  logic [9:0]  dvs;
  logic [10:0] shifted;
  logic [11:0] diff;
  logic        ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    shifted = {rem, quo[19]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    ge      = ~diff[11];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == 5'd19);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd19) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath; a zero divisor divides as one
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= (divisor == '0) ? 10'd1 : divisor;
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[9:0] : shifted[9:0];
      quo <= {quo[18:0], ge};
    end
  end

  assign quotient = quo;

endmodule
